// File: src/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

  localparam int unsigned RadixW = 6;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitsPerCycle = 4;

  localparam logic [RadixW-1:0] DecRadix   = 6'd10;
  localparam logic [RadixW-1:0] MinRadix   = 6'd2;
  localparam logic [RadixW-1:0] MaxRadix   = 6'd36;
  localparam logic [CharW-1:0]  AsciiZero  = 8'h30;
  localparam logic [CharW-1:0]  AsciiMinus = 8'h2D;
  localparam logic [CharW-1:0]  AlphaOffset = 8'd7;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             final_char;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SIGN = 5'b00100,
    S_RD   = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_e;

  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [CharW-1:0] c;
    c = AsciiZero + {2'b00, d};
    if (d >= DecRadix) begin
      c = c + AlphaOffset;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/itoa_fifo.sv
`default_nettype none

module itoa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/itoa_front.sv
`default_nettype none

module itoa_front
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [RadixW-1:0]     cfg_data_i,
  input  wire logic [VALUE_BITS-1:0] number_i,
  output logic [VALUE_BITS-1:0]      mag_o,
  output logic                       print_sign_o,
  output logic [RadixW-1:0]          radix_o
);

  logic [RadixW-1:0] radix_q, radix_d;
  logic              negative;

  assign cfg_ready_o = 1'b1;

  // clamp the base into its legal range
  always_comb begin
    radix_d = radix_q;
    if (cfg_valid_i) begin
      priority if (cfg_data_i < MinRadix) begin
        radix_d = MinRadix;
      end else if (cfg_data_i > MaxRadix) begin
        radix_d = MaxRadix;
      end else begin
        radix_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= DecRadix;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign negative     = number_i[VALUE_BITS-1];
  assign mag_o        = negative ? (~number_i + 1'b1) : number_i;
  assign print_sign_o = negative && (radix_q == DecRadix);
  assign radix_o      = radix_q;

endmodule

`default_nettype wire

// File: src/itoa_back.sv
`default_nettype none

module itoa_back
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_empty_i,
  output logic                       item_pop_o,
  input  wire logic [VALUE_BITS-1:0] item_mag_i,
  input  wire logic                  item_print_sign_i,
  input  wire logic [RadixW-1:0]     item_radix_i,
  output logic                       res_push_o,
  output res_t                       res_o,
  input  wire logic                  res_full_i
);

  localparam int unsigned MagW  = ((VALUE_BITS + DigitsPerCycle - 1) / DigitsPerCycle)
                                  * DigitsPerCycle;
  localparam int unsigned Steps = MagW / DigitsPerCycle;
  localparam int unsigned StepW = (Steps > 1) ? $clog2(Steps) : 1;
  localparam int unsigned CntW  = $clog2(VALUE_BITS + 1);
  localparam int unsigned IdxW  = $clog2(VALUE_BITS);

  back_state_e       state_q, state_d;
  logic [MagW-1:0]   div_q, div_d;
  logic [RadixW-1:0] rem_q, rem_d;
  logic [RadixW-1:0] radix_q, radix_d;
  logic              print_sign_q, print_sign_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [CharW-1:0]  stack_q [VALUE_BITS];
  logic [CharW-1:0]  rd_data_q;
  logic              wr_en, rd_en;
  logic [IdxW-1:0]   wr_addr, rd_addr;
  logic [CntW-1:0]   cnt_dec;

  logic [RadixW:0]         trial;
  logic [RadixW-1:0]       part_rem;
  logic [DigitsPerCycle-1:0] qbits;
  logic [MagW-1:0]         div_next;
  logic                    last_step;

  // four restoring division steps per cycle
  always_comb begin
    part_rem = rem_q;
    qbits    = '0;
    trial    = '0;
    for (int i = 0; i < DigitsPerCycle; i++) begin
      trial = {part_rem, div_q[MagW-1-i]};
      if (trial >= {1'b0, radix_q}) begin
        trial = trial - {1'b0, radix_q};
        qbits[DigitsPerCycle-1-i] = 1'b1;
      end
      part_rem = trial[RadixW-1:0];
    end
  end

  assign div_next  = {div_q[MagW-DigitsPerCycle-1:0], qbits};
  assign last_step = (step_q == StepW'(Steps - 1));
  assign cnt_dec   = cnt_q - 1'b1;
  assign wr_addr   = cnt_q[IdxW-1:0];
  assign rd_addr   = cnt_dec[IdxW-1:0];
  assign wr_en     = (state_q == S_DIV) && last_step;
  assign rd_en     = (state_q == S_RD);
  assign item_pop_o = (state_q == S_IDLE) && !item_empty_i;

  always_comb begin
    state_d      = state_q;
    div_d        = div_q;
    rem_d        = rem_q;
    radix_d      = radix_q;
    print_sign_d = print_sign_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    res_push_o   = 1'b0;
    res_o        = '{character: rd_data_q, final_char: (cnt_q == '0)};
    unique case (state_q)
      S_IDLE: begin
        if (!item_empty_i) begin
          div_d        = MagW'(item_mag_i);
          rem_d        = '0;
          radix_d      = item_radix_i;
          print_sign_d = item_print_sign_i;
          step_d       = '0;
          cnt_d        = '0;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        div_d  = div_next;
        rem_d  = part_rem;
        step_d = step_q + 1'b1;
        if (last_step) begin
          rem_d  = '0;
          step_d = '0;
          cnt_d  = cnt_q + 1'b1;
          if (div_next == '0) begin
            state_d = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (print_sign_q) begin
          res_o      = '{character: AsciiMinus, final_char: 1'b0};
          res_push_o = 1'b1;
          if (!res_full_i) begin
            state_d = S_RD;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cnt_d   = cnt_dec;
        state_d = S_OUT;
      end
      S_OUT: begin
        res_push_o = 1'b1;
        if (!res_full_i) begin
          state_d = (cnt_q == '0) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q        <= div_d;
    rem_q        <= rem_d;
    radix_q      <= radix_d;
    print_sign_q <= print_sign_d;
  end

  // digit stack: written least significant first, read back in reverse
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_q[wr_addr] <= digit_char(part_rem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= stack_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/integer_to_ascii_radix.sv
// Integer to ASCII conversion in a programmable base.
//
// Input queue: drive number_i and raise push; a beat is taken on a clock edge
// with push high and full low. Output queue: while empty is low, character_o
// and final_char_o show the oldest character; pop high takes that beat.
// final_char_o marks the last character of each number. A '-' leads negative
// numbers in base 10 only; other bases print the magnitude.
// Config: cfg_data_i is the base, taken when cfg_valid_i and cfg_ready_o are
// high; values outside 2..36 are clamped. Write it only while idle.
// Flow: a two-entry queue holds accepted numbers while the digit engine
// works. The engine divides four bits per cycle and runs over the whole
// magnitude for each digit, after a load step in the idle state. A sign
// step follows, taken whether or not a '-' is sent. Digits are then played
// out of a digit stack, each through a read state and an output state; the
// engine takes no new number until its last character has been pushed.
// Reset sets the base to 10 and empties both queues. When the receiver stalls,
// the output queue fills, the engine holds, and full rises once the input
// queue is also filled.
`default_nettype none

module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [RadixW-1:0]     cfg_data_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [VALUE_BITS-1:0] number_i,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [CharW-1:0]           character_o,
  output logic                       final_char_o
);

  localparam int unsigned ItemW = VALUE_BITS + 1 + RadixW;
  localparam int unsigned QDepth = 2;

  logic [VALUE_BITS-1:0] front_mag, back_mag;
  logic                  front_print_sign, back_print_sign;
  logic [RadixW-1:0]     front_radix, back_radix;
  logic                  item_empty, item_pop;
  res_t                  back_res, out_res;
  logic                  res_push, res_full;

  itoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .number_i    (number_i),
    .mag_o       (front_mag),
    .print_sign_o(front_print_sign),
    .radix_o     (front_radix)
  );

  itoa_fifo #(
    .WIDTH(ItemW),
    .DEPTH(QDepth)
  ) u_item_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({front_radix, front_print_sign, front_mag}),
    .full_o (full),
    .pop_i  (item_pop),
    .data_o ({back_radix, back_print_sign, back_mag}),
    .empty_o(item_empty)
  );

  itoa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_empty_i     (item_empty),
    .item_pop_o       (item_pop),
    .item_mag_i       (back_mag),
    .item_print_sign_i(back_print_sign),
    .item_radix_i     (back_radix),
    .res_push_o       (res_push),
    .res_o            (back_res),
    .res_full_i       (res_full)
  );

  itoa_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  assign character_o  = out_res.character;
  assign final_char_o = out_res.final_char;

endmodule

`default_nettype wire
